// ===== sv/mtct_pkg.sv =====
package mtct_pkg;

    localparam int NUM_THREADS   = 8;
    localparam int WORD_BITS     = 32;
    localparam int IN_BITS       = NUM_THREADS * WORD_BITS;
    localparam int OUT_DATA_BITS = ((NUM_THREADS * WORD_BITS + 1 + 7) / 8) * 8;
    localparam int PAD_BITS      = OUT_DATA_BITS - NUM_THREADS * WORD_BITS - 1;

    localparam logic [0:0] REG_THREAD_COUNT    = 1'b0;
    localparam logic [0:0] REG_BITS_PER_SAMPLE = 1'b1;

    localparam logic [1:0] THREAD_COUNT_RESET    = 2'd0;
    localparam logic [2:0] BITS_PER_SAMPLE_RESET = 3'd1;

    typedef logic [NUM_THREADS-1:0][WORD_BITS-1:0] word_array_t;

    typedef struct packed {
        logic [1:0] thread_count_log2;
        logic [2:0] bits_per_sample_log2;
    } cfg_t;

    typedef struct packed {
        logic        config_error;
        word_array_t out_words;
    } result_t;

endpackage

// ===== sv/mtct_cfg_regs.sv =====
module mtct_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [2:0]        cfg_data,
    output mtct_pkg::cfg_t    cfg
);
    import mtct_pkg::*;

    logic [1:0] thread_count_log2_reg;
    logic [2:0] bits_per_sample_log2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thread_count_log2_reg    <= THREAD_COUNT_RESET;
            bits_per_sample_log2_reg <= BITS_PER_SAMPLE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_THREAD_COUNT:
                begin
                    thread_count_log2_reg <= cfg_data[1:0];
                end
                REG_BITS_PER_SAMPLE:
                begin
                    bits_per_sample_log2_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.thread_count_log2    = thread_count_log2_reg;
    assign cfg.bits_per_sample_log2 = bits_per_sample_log2_reg;

endmodule

// ===== sv/mtct_turn.sv =====
module mtct_turn (
    input  mtct_pkg::cfg_t        cfg,
    input  mtct_pkg::word_array_t thread_words,
    output mtct_pkg::result_t     result
);
    import mtct_pkg::*;

    logic [1:0] t;
    logic [2:0] bb;
    logic       too_wide;
    logic [2:0] thread_mask;
    logic [4:0] bit_mask;

    assign t  = cfg.thread_count_log2;
    assign bb = cfg.bits_per_sample_log2;

    // A whole time step of N samples must fit in one word.
    assign too_wide    = ({2'b00, t} + {1'b0, bb}) > 4'd5;
    assign thread_mask = 3'((4'd1 << t) - 4'd1);
    assign bit_mask    = 5'((6'd1 << bb) - 6'd1);

    always_comb
    begin
        logic [4:0] slot;
        logic [2:0] src_thread;
        logic [4:0] step;
        logic [4:0] src_bit;
        logic [4:0] word_base;

        result = '0;
        result.config_error = too_wide;
        for (int j = 0; j < NUM_THREADS; j++)
        begin
            for (int p = 0; p < WORD_BITS; p++)
            begin
                slot       = 5'(p) >> bb;
                src_thread = slot[2:0] & thread_mask;
                step       = slot >> t;
                word_base  = 5'(5'(j) << (3'd5 - {1'b0, t}));
                src_bit    = word_base + 5'(step << bb) + (5'(p) & bit_mask);
                if (!too_wide && (4'(j) < (4'd1 << t)))
                begin
                    result.out_words[j][p] = thread_words[src_thread][src_bit];
                end
            end
        end
    end

endmodule

// ===== sv/multithread_sample_corner_turn_core.sv =====
// Input transfers go to the input register; turned results are held in the result register.
// Throughput: one item per cycle; an input transfer can be taken in every cycle while the
// output side keeps accepting, the input register and the result register each hold one item.
// Reset clears both pipeline valid flags and returns the thread count and sample width
// registers to one thread of two-bit samples.
module multithread_sample_corner_turn_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // thread_word_0 .. thread_word_7, 32 bits each, from the lowest bit up.
    input  logic [mtct_pkg::IN_BITS-1:0]         s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // out_word_0 .. out_word_7 (32 bits each), config_error, then zero padding.
    output logic [mtct_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    input  logic                                 cfg_we,
    input  logic [0:0]                           cfg_index,
    input  logic [2:0]                           cfg_data
);
    import mtct_pkg::*;

    cfg_t        cfg;
    word_array_t in_words_reg;
    logic        in_valid_reg;
    result_t     turned;
    result_t     result_reg;
    logic        out_valid_reg;
    logic        out_advance;
    logic        in_advance;

    mtct_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mtct_turn u_turn (
        .cfg          (cfg),
        .thread_words (in_words_reg),
        .result       (turned)
    );

    assign out_advance = !out_valid_reg || m_tready;
    assign in_advance  = !in_valid_reg || out_advance;
    assign s_tready    = in_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_advance)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_advance && s_tvalid)
        begin
            in_words_reg <= s_tdata;
        end
        if (out_advance && in_valid_reg)
        begin
            result_reg <= turned;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_BITS{1'b0}}, result_reg.config_error, result_reg.out_words};

endmodule
